/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/tenb64_pkg.sv */
// ----------------------------------------------------------------------------
// Tenths to binary64 package
// Sequencer states and fixed constants of the conversion core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tenb64_pkg;

    // Biased exponent of a value in [1, 2).
    localparam logic [10:0] EXP_BIAS  = 11'd1023;
    // Number of fraction bits produced by the divider.
    localparam int          FRAC_BITS = 52;
    // Divisor that turns tenths into units.
    localparam logic [3:0]  TEN       = 4'd10;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_NORM_UP,
        ST_NORM_DN,
        ST_SUB,
        ST_DIV,
        ST_ROUND
    } state_t;

endpackage

`default_nettype wire

/* rtl/core/tenths_to_binary64_core.sv */
// ----------------------------------------------------------------------------
// Tenths to binary64 conversion core
// Converts a signed value in tenths into the binary64 pattern of value / 10.
// ----------------------------------------------------------------------------
// A transfer is taken when start is high while busy is low. The core then
// works on that one value alone and keeps busy high until the result is out.
// Every compare and remainder subtraction runs through a single shared
// 18-bit subtract and compare unit under a small sequencer: a start state
// classifies the magnitude, one step per cycle normalizes it against ten
// times a power of two (up to twelve steps for large values, up to four for
// values below one unit), a subtract state forms the first remainder where
// needed, a restoring division yields the 52 fraction bits, and a final
// state rounds to nearest even. A zero input is answered in the very next
// cycle. The result appears on double_bits flagged by done, which is high
// for exactly one cycle, and busy falls in that same cycle, so a new
// transfer may be issued while the result is being read. There is no
// way for the receiver to hold a result back: it must capture it while done
// is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module tenths_to_binary64_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output      logic               busy,
    input  wire logic signed [15:0] tenths_value,
    output      logic               done,
    output      logic        [63:0] double_bits
);

    import tenb64_pkg::*;

    // Last fraction bit index of the division counter.
    localparam logic [5:0] LAST_BIT = 6'(FRAC_BITS - 1);

    state_t        state_reg, state_next;
    logic          done_reg, done_next;
    logic [63:0]   result_reg, result_next;
    logic          neg_reg, neg_next;
    logic [16:0]   mag_reg, mag_next;
    logic [14:0]   den_reg, den_next;
    logic [15:0]   rem_reg, rem_next;
    logic [10:0]   exp_reg, exp_next;
    logic [51:0]   frac_reg, frac_next;
    logic [5:0]    count_reg, count_next;

    // Shared subtract and compare unit.
    logic [17:0]   opa;
    logic [17:0]   opb;
    logic [17:0]   diff;
    logic          ge;

    logic          accept;
    logic          round_up;
    logic [62:0]   rounded;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign double_bits = result_reg;

    // Operand selection for the shared unit.
    always_comb
    begin
        opa = {1'b0, mag_reg};
        opb = {14'd0, TEN};
        case (state_reg)
            ST_START:
            begin
                opa = {1'b0, mag_reg};
                opb = {14'd0, TEN};
            end
            ST_NORM_UP:
            begin
                opa = {1'b0, mag_reg};
                opb = {2'b00, den_reg, 1'b0};
            end
            ST_NORM_DN:
            begin
                opa = {2'b00, rem_reg};
                opb = {14'd0, TEN};
            end
            ST_SUB:
            begin
                opa = {1'b0, mag_reg};
                opb = {3'b000, den_reg};
            end
            ST_DIV, ST_ROUND:
            begin
                opa = {1'b0, rem_reg, 1'b0};
                opb = {3'b000, den_reg};
            end
            default:
            begin
                opa = {1'b0, mag_reg};
                opb = {14'd0, TEN};
            end
        endcase
    end

    // Both operands stay below 2^17, so bit 17 of the difference is the borrow.
    assign diff = opa - opb;
    assign ge   = !diff[17];

    // Round to nearest, ties to even: twice the remainder against the divisor.
    assign round_up = (ge && (diff != 18'd0)) || ((diff == 18'd0) && frac_reg[0]);
    assign rounded  = {exp_reg, frac_reg} + {62'd0, round_up};

    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        neg_next    = neg_reg;
        mag_next    = mag_reg;
        den_next    = den_reg;
        rem_next    = rem_reg;
        exp_next    = exp_reg;
        frac_next   = frac_reg;
        count_next  = count_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    neg_next = tenths_value[15];
                    if (tenths_value[15])
                        mag_next = 17'h10000 - {1'b0, tenths_value};
                    else
                        mag_next = {1'b0, tenths_value};
                    if (tenths_value == 16'sd0)
                    begin
                        // Zero is positive zero, answered at once.
                        result_next = 64'd0;
                        done_next   = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_START;
                    end
                end
            end
            ST_START:
            begin
                if (ge)
                begin
                    // At least one unit: scale the divisor up.
                    den_next   = 15'({11'd0, TEN});
                    exp_next   = EXP_BIAS;
                    state_next = ST_NORM_UP;
                end
                else
                begin
                    // Below one unit: scale the remainder up instead.
                    den_next   = 15'({11'd0, TEN});
                    rem_next   = {mag_reg[14:0], 1'b0};
                    exp_next   = EXP_BIAS - 11'd1;
                    state_next = ST_NORM_DN;
                end
            end
            ST_NORM_UP:
            begin
                if (ge)
                begin
                    den_next = {den_reg[13:0], 1'b0};
                    exp_next = exp_reg + 11'd1;
                end
                else
                begin
                    state_next = ST_SUB;
                end
            end
            ST_NORM_DN:
            begin
                if (ge)
                begin
                    rem_next   = diff[15:0];
                    count_next = 6'd0;
                    state_next = ST_DIV;
                end
                else
                begin
                    rem_next = {rem_reg[14:0], 1'b0};
                    exp_next = exp_reg - 11'd1;
                end
            end
            ST_SUB:
            begin
                rem_next   = diff[15:0];
                count_next = 6'd0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (ge)
                    rem_next = diff[15:0];
                else
                    rem_next = {rem_reg[14:0], 1'b0};
                frac_next  = {frac_reg[50:0], ge};
                count_next = count_reg + 6'd1;
                if (count_reg == LAST_BIT)
                    state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                // A carry out of the fraction lands in the exponent field.
                result_next = {neg_reg, rounded};
                done_next   = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        neg_reg    <= neg_next;
        mag_reg    <= mag_next;
        den_reg    <= den_next;
        rem_reg    <= rem_next;
        exp_reg    <= exp_next;
        frac_reg   <= frac_next;
        count_reg  <= count_next;
    end

    // A result is only flagged once the sequencer has let go of the value.
    `ASSERT_SAME(a_done_not_busy, done_reg, !busy, "done raised while busy")
    // The division never runs past the last fraction bit.
    `ASSERT_SAME(a_count_range, state_reg == ST_DIV, count_reg <= LAST_BIT,
                 "division counter out of range")
    // The restoring division keeps the remainder below the divisor.
    `ASSERT_SAME(a_rem_below_den, state_reg == ST_DIV || state_reg == ST_ROUND,
                 {1'b0, rem_reg} < {2'b00, den_reg}, "remainder not below divisor")
    // Zero input is answered with positive zero in the next cycle.
    `ASSERT_NEXT(a_zero_fast, accept && (tenths_value == 16'sd0),
                 done && (double_bits == 64'd0), "zero input not answered at once")
    // The working exponent stays inside the range reachable from 16-bit input.
    `ASSERT_SAME(a_exp_range, state_reg == ST_DIV,
                 (exp_reg >= (EXP_BIAS - 11'd4)) && (exp_reg <= (EXP_BIAS + 11'd11)),
                 "exponent out of range")

endmodule

`default_nettype wire

/* dv/tenths_to_binary64_core_tb.sv */
// ----------------------------------------------------------------------------
// Tenths to binary64 core testbench
// Drives signed tenths readings into the conversion core and checks every
// binary64 pattern it returns against a typed pattern or a bit-exact software conversion.
// ----------------------------------------------------------------------------
// The run starts with a table of hand-picked readings. Some rows carry the
// pattern typed in, and the rest are checked against the conversion
// function below. A long random phase follows. Its readings are weighted
// toward the places where the core's sequencer changes course: values below
// one unit, values next to ten times a power of two, and the extremes of
// the 16-bit range. The sender waits a random gap of up to MAX_GAP before
// each transfer. Some stretches of the run have no waiting at all, so that
// new requests meet the core at every point of its work, including the
// cycle in which done is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tenths_to_binary64_core_tb;

    import tenb64_pkg::*;

    // Half periods of the 8 ns clock.
    localparam int CLK_HIGH_NS     = 4;
    localparam int CLK_LOW_NS      = 4;
    localparam int RESET_CYCLES    = 6;
    // The limit covers the slowest conversion, with the longest sender gap
    // and generous margin on top of that.
    localparam int STALL_LIMIT     = 1000;
    localparam int DRAIN_CYCLES    = 80;
    localparam int RANDOM_READINGS = 1700;
    localparam int MAX_GAP         = 11;

    // Kinds of random reading.
    typedef enum int {
        PICK_ANY,
        PICK_BELOW_UNIT,
        PICK_NEAR_BOUNDARY,
        PICK_EXTREME
    } reading_kind_t;

    // One row of the directed table. When pinned is set, want holds the
    // pattern typed in by hand. Otherwise the conversion function decides.
    typedef struct {
        logic [15:0] reading;
        bit          pinned;
        logic [63:0] want;
    } directed_row_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [15:0] tenths_value;
    logic               done;
    logic        [63:0] double_bits;

    // Binary64 patterns that are still owed by the core, oldest first.
    logic [63:0] pending_doubles[$];
    int          mismatch_count;
    int          stall_cycles;
    // A typed pattern for the reading that is now on the port, if any.
    bit          pin_next;
    logic [63:0] pinned_double;
    // When this is set, the sender issues transfers back to back.
    bit          burst_mode;

    tenths_to_binary64_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .tenths_value (tenths_value),
        .done         (done),
        .double_bits  (double_bits)
    );

    always
    begin
        clk = 1'b1;
        #CLK_HIGH_NS;
        clk = 1'b0;
        #CLK_LOW_NS;
    end

    // Converts a reading in tenths to the binary64 pattern of reading / 10,
    // rounded to nearest with ties to even.
    function automatic logic [63:0] tenths_to_double(input logic [15:0] reading);
        logic        negative;
        logic [31:0] magnitude;
        logic [31:0] divisor;
        logic [31:0] remainder;
        logic [51:0] fraction;
        logic [63:0] pattern;
        int          exponent;
        if (reading == 16'd0)
            return 64'd0;
        negative = reading[15];
        // The magnitude of -32768 fits here because the width is 32 bits.
        magnitude = negative ? (32'h10000 - {16'd0, reading}) : {16'd0, reading};
        divisor   = 32'(TEN);
        exponent  = 0;
        if (magnitude >= 32'(TEN))
        begin
            // Scale the divisor up to the largest ten times 2^k that still
            // fits under the magnitude. The leading one is then implied.
            while ((divisor << 1) <= magnitude)
            begin
                divisor = divisor << 1;
                exponent++;
            end
            remainder = magnitude - divisor;
        end
        else
        begin
            // Below one unit, scale the magnitude up instead of the divisor.
            remainder = magnitude << 1;
            exponent  = -1;
            while (remainder < 32'(TEN))
            begin
                remainder = remainder << 1;
                exponent--;
            end
            remainder = remainder - 32'(TEN);
        end
        fraction = '0;
        for (int i = 0; i < FRAC_BITS; i++)
        begin
            remainder = remainder << 1;
            fraction  = fraction << 1;
            if (remainder >= divisor)
            begin
                remainder   = remainder - divisor;
                fraction[0] = 1'b1;
            end
        end
        pattern = {1'b0, 11'(int'(EXP_BIAS) + exponent), fraction};
        // Round to nearest with ties to even. A carry out of the fraction
        // moves into the exponent field on its own.
        if (((remainder << 1) > divisor) ||
            (((remainder << 1) == divisor) && fraction[0]))
            pattern = pattern + 64'd1;
        pattern[63] = negative;
        return pattern;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] %s: got %016h, want %016h", $time, what, got, want);
        mismatch_count++;
    endtask

    // All sampling happens at the rising edge. A result that comes out in
    // the same cycle as a new transfer is matched first, so that the order
    // of the queue stays the order of the transfers.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_doubles.size() == 0)
                    report_mismatch("result with no transfer outstanding",
                                    double_bits, 64'hx);
                else
                begin
                    logic [63:0] want;
                    want = pending_doubles.pop_front();
                    if (double_bits !== want)
                        report_mismatch("double_bits", double_bits, want);
                end
            end
            if (start && !busy)
                pending_doubles.push_back(pin_next ? pinned_double
                                                   : tenths_to_double(tenths_value));
        end
    end

    // Watchdog. It counts the cycles in which neither a transfer nor a
    // result is taken, and ends the run when that count grows too long.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("[%0t] timeout: no transfer or result for %0d cycles",
                     $time, STALL_LIMIT);
            $display("tenths_to_binary64_core: mismatch");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // Issues one reading. The task returns at the falling edge after the
    // transfer is taken. If the next call has no gap, start simply stays high.
    task automatic send_reading(input logic [15:0] reading, input bit pinned,
                                input logic [63:0] want);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            start <= 1'b0;
            // The data port carries junk while start is low. The core must
            // ignore it.
            tenths_value <= 16'($urandom);
            repeat (gap) @(negedge clk);
        end
        pin_next      = pinned;
        pinned_double = want;
        start        <= 1'b1;
        tenths_value <= reading;
        // busy is read before the edge updates it, so a low value here
        // means the transfer is taken at this edge.
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    function automatic logic [15:0] random_reading();
        reading_kind_t kind;
        logic [15:0]   reading;
        int            roll;
        roll = $urandom_range(0, 9);
        if (roll < 4)
            kind = PICK_ANY;
        else if (roll < 6)
            kind = PICK_BELOW_UNIT;
        else if (roll < 9)
            kind = PICK_NEAR_BOUNDARY;
        else
            kind = PICK_EXTREME;
        case (kind)
            PICK_ANY:
                reading = 16'($urandom_range(0, 16'hFFFF));
            PICK_BELOW_UNIT:
                reading = 16'($urandom_range(0, 18) - 9);
            PICK_NEAR_BOUNDARY:
            begin
                // Land on or beside ten times 2^k, where the normalization
                // stops one step earlier or later.
                reading = 16'((10 << $urandom_range(0, 11)) + $urandom_range(0, 2) - 1);
                if ($urandom_range(0, 1))
                    reading = -reading;
            end
            default:
            begin
                case ($urandom_range(0, 5))
                    0:       reading = 16'h7FFF;
                    1:       reading = 16'h8000;
                    2:       reading = 16'h8001;
                    3:       reading = 16'h0000;
                    4:       reading = 16'd10;
                    default: reading = 16'hFFF6;
                endcase
            end
        endcase
        return reading;
    endfunction

    // Directed readings. Each pinned pattern can be checked by hand.
    directed_row_t directed_rows[] = '{
        '{16'd0,      1'b1, 64'h0000_0000_0000_0000},  // zero
        '{16'd10,     1'b1, 64'h3FF0_0000_0000_0000},  // 1.0
        '{16'hFFF6,   1'b1, 64'hBFF0_0000_0000_0000},  // -1.0
        '{16'd5,      1'b1, 64'h3FE0_0000_0000_0000},  // 0.5
        '{16'd1,      1'b1, 64'h3FB9_9999_9999_999A},  // 0.1, rounded up
        '{16'hFFFF,   1'b1, 64'hBFB9_9999_9999_999A},  // -0.1
        '{16'd20,     1'b1, 64'h4000_0000_0000_0000},  // 2.0
        '{16'd15,     1'b1, 64'h3FF8_0000_0000_0000},  // 1.5
        '{16'd25,     1'b1, 64'h4004_0000_0000_0000},  // 2.5
        '{16'd20480,  1'b1, 64'h40A0_0000_0000_0000},  // 2048.0, largest scale
        '{16'd32760,  1'b1, 64'h40A9_9800_0000_0000},  // 3276.0
        '{16'h7FFF,   1'b0, 64'h0},                    // largest positive
        '{16'h8000,   1'b0, 64'h0},                    // most negative
        '{16'h8001,   1'b0, 64'h0},
        '{16'd2,      1'b0, 64'h0},                    // values below one unit
        '{16'd3,      1'b0, 64'h0},
        '{16'd9,      1'b0, 64'h0},
        '{16'd11,     1'b0, 64'h0},
        '{16'd19,     1'b0, 64'h0},
        '{16'd39,     1'b0, 64'h0},
        '{16'd20479,  1'b0, 64'h0},
        '{16'd20481,  1'b0, 64'h0},
        '{16'hFFFB,   1'b0, 64'h0},
        '{16'd0,      1'b1, 64'h0000_0000_0000_0000}   // zero again, back to back
    };

    initial
    begin
        rst_n          = 1'b0;
        start          = 1'b0;
        tenths_value   = '0;
        pin_next       = 1'b0;
        pinned_double  = '0;
        burst_mode     = 1'b0;
        mismatch_count = 0;
        stall_cycles   = 0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            // The last two rows go back to back.
            burst_mode = (i >= directed_rows.size() - 2);
            send_reading(directed_rows[i].reading, directed_rows[i].pinned,
                         directed_rows[i].want);
        end

        for (int n = 0; n < RANDOM_READINGS; n++)
        begin
            // Switch between back-to-back and gapped sending in stretches.
            if (n % 50 == 0)
                burst_mode = ($urandom_range(0, 3) == 0);
            send_reading(random_reading(), 1'b0, 64'h0);
        end
        start <= 1'b0;

        while (pending_doubles.size() != 0)
            @(posedge clk);
        // Any late extra result would show up in this window.
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_doubles.size() == 0)
            $display("tenths_to_binary64_core: match");
        else
            $display("tenths_to_binary64_core: mismatch");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/tenb64_pkg.sv
rtl/core/tenths_to_binary64_core.sv
dv/tenths_to_binary64_core_tb.sv
